// ===== hdl/csv_stream_tokenizer_unit_assert.svh =====
// assertion macros shared by the tokenizer checker
`ifndef CSV_STREAM_TOKENIZER_UNIT_ASSERT_SVH
`define CSV_STREAM_TOKENIZER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CSVT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csvt assertion failed");

// next-cycle implication, disabled during reset
`define CSVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csvt assertion failed");

`endif

// ===== hdl/csvt_pkg.sv =====
// ----------------------------------------------------------------------------
// csvt_pkg
// Types and constants shared by the CSV stream tokenizer modules.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam int LINE_BITS_DEF = 32;
  localparam int ERR_LINE_W    = 32;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    MODE_UNQ    = 2'd0,
    MODE_QUOTED = 2'd1,
    MODE_QPEND  = 2'd2,
    MODE_CLOSED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_BYTE   = 3'd0,
    EV_FIELD  = 3'd1,
    EV_RECORD = 3'd2,
    EV_ERROR  = 3'd3,
    EV_DONE   = 3'd4
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t                kind;
    logic [7:0]              fbyte;
    logic [ERR_LINE_W-1:0]   line;
    logic                    last;
  } result_t;

  // results produced by one accepted item
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ===== hdl/csv_stream_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// csv_stream_tokenizer_unit
// Streaming CSV tokenizer: bytes in, byte/field/record/error/done events out.
// ----------------------------------------------------------------------------
// Takes one text byte or end-of-text item per cycle and answers each with zero,
// one or two events; a byte's event is registered in the result queue. The
// parser state update is a single registered step, so with the output drained
// the block sustains one item per clock. Results pass through a three-entry
// queue, and in_ready is low whenever the queue holds two or more results, so
// an end of text that yields both end-of-record and done, or a stalled output,
// can hold the input. Line numbers count from 1 and saturate at LINE_BITS
// ones; error_line carries the low 32 bits.
module csv_stream_tokenizer_unit #(
  parameter int LINE_BITS = csvt_pkg::LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [7:0]  out_field_byte,
  output logic [31:0] out_error_line,
  output logic        out_last_of_run
);
  import csvt_pkg::*;

  push_t   push;
  result_t head;
  logic    accept;

  assign accept = in_valid && in_ready;

  csvt_core #(
    .LINE_BITS (LINE_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .opcode    (in_opcode),
    .text_byte (in_text_byte),
    .push      (push)
  );

  csvt_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  assign out_event_kind  = head.kind;
  assign out_field_byte  = head.fbyte;
  assign out_error_line  = head.line;
  assign out_last_of_run = head.last;

endmodule

// ===== hdl/csvt_core.sv =====
// ----------------------------------------------------------------------------
// csvt_core
// Parser state and per-byte decode; produces up to two results per item.
// ----------------------------------------------------------------------------
module csvt_core #(
  parameter int LINE_BITS = csvt_pkg::LINE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic            opcode,
  input  logic [7:0]      text_byte,
  output csvt_pkg::push_t push
);
  import csvt_pkg::*;

  mode_t                mode_r, mode_nxt;
  logic                 touched_r, touched_nxt;
  logic                 nonempty_r, nonempty_nxt;
  logic                 prevcr_r, prevcr_nxt;
  logic                 err_r, err_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;

  logic [LINE_BITS-1:0] line_inc;
  logic [ERR_LINE_W-1:0] line_out;
  logic                 crlf_tail;
  logic                 is_eol;

  assign line_inc  = (line_r != '1) ? line_r + 1'b1 : line_r;
  assign line_out  = ERR_LINE_W'(line_r);
  assign crlf_tail = prevcr_r && (text_byte == CH_LF);
  assign is_eol    = (text_byte == CH_CR) || (text_byte == CH_LF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_UNQ;
      touched_r  <= 1'b0;
      nonempty_r <= 1'b0;
      prevcr_r   <= 1'b0;
      err_r      <= 1'b0;
      line_r     <= LINE_BITS'(1);
    end else begin
      mode_r     <= mode_nxt;
      touched_r  <= touched_nxt;
      nonempty_r <= nonempty_nxt;
      prevcr_r   <= prevcr_nxt;
      err_r      <= err_nxt;
      line_r     <= line_nxt;
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    touched_nxt  = touched_r;
    nonempty_nxt = nonempty_r;
    prevcr_nxt   = prevcr_r;
    err_nxt      = err_r;
    line_nxt     = line_r;
    push         = '0;
    push.r0.kind = EV_BYTE;
    push.r1.kind = EV_BYTE;

    if (accept) begin
      if (opcode) begin
        if (!err_r) begin
          if (mode_r == MODE_QUOTED) begin
            push.n       = 2'd1;
            push.r0.kind = EV_ERROR;
            push.r0.line = line_out;
          end else if (touched_r || mode_r != MODE_UNQ) begin
            push.n       = 2'd2;
            push.r0.kind = EV_RECORD;
            push.r1.kind = EV_DONE;
          end else begin
            push.n       = 2'd1;
            push.r0.kind = EV_DONE;
          end
        end
        // end of text returns to the reset state
        mode_nxt     = MODE_UNQ;
        touched_nxt  = 1'b0;
        nonempty_nxt = 1'b0;
        prevcr_nxt   = 1'b0;
        err_nxt      = 1'b0;
        line_nxt     = LINE_BITS'(1);
      end else if (!err_r) begin
        prevcr_nxt = (text_byte == CH_CR);
        case (mode_r)
          MODE_UNQ: begin
            if (text_byte == CH_QUOTE) begin
              if (nonempty_r) begin
                push.n       = 2'd1;
                push.r0.kind = EV_ERROR;
                push.r0.line = line_out;
                err_nxt      = 1'b1;
              end else begin
                mode_nxt    = MODE_QUOTED;
                touched_nxt = 1'b1;
              end
            end else if (text_byte == CH_COMMA) begin
              push.n       = 2'd1;
              push.r0.kind = EV_FIELD;
              nonempty_nxt = 1'b0;
              touched_nxt  = 1'b1;
            end else if (is_eol) begin
              // lf of a crlf is swallowed
              if (!crlf_tail) begin
                if (touched_r) begin
                  push.n       = 2'd1;
                  push.r0.kind = EV_RECORD;
                end
                mode_nxt     = MODE_UNQ;
                touched_nxt  = 1'b0;
                nonempty_nxt = 1'b0;
                line_nxt     = line_inc;
              end
            end else begin
              push.n        = 2'd1;
              push.r0.kind  = EV_BYTE;
              push.r0.fbyte = text_byte;
              nonempty_nxt  = 1'b1;
              touched_nxt   = 1'b1;
            end
          end
          MODE_QUOTED: begin
            if (text_byte == CH_QUOTE) begin
              mode_nxt = MODE_QPEND;
            end else begin
              push.n        = 2'd1;
              push.r0.kind  = EV_BYTE;
              push.r0.fbyte = text_byte;
              if (text_byte == CH_CR || (text_byte == CH_LF && !crlf_tail)) begin
                line_nxt = line_inc;
              end
            end
          end
          default: begin
            if (text_byte == CH_QUOTE && mode_r == MODE_QPEND) begin
              push.n        = 2'd1;
              push.r0.kind  = EV_BYTE;
              push.r0.fbyte = CH_QUOTE;
              mode_nxt      = MODE_QUOTED;
            end else if (text_byte == CH_COMMA) begin
              push.n       = 2'd1;
              push.r0.kind = EV_FIELD;
              mode_nxt     = MODE_UNQ;
              nonempty_nxt = 1'b0;
            end else if (is_eol) begin
              if (touched_r) begin
                push.n       = 2'd1;
                push.r0.kind = EV_RECORD;
              end
              mode_nxt     = MODE_UNQ;
              touched_nxt  = 1'b0;
              nonempty_nxt = 1'b0;
              line_nxt     = line_inc;
            end else begin
              push.n       = 2'd1;
              push.r0.kind = EV_ERROR;
              push.r0.line = line_out;
              err_nxt      = 1'b1;
            end
          end
        endcase
      end
    end

    // flag the final result of this item
    push.r0.last = (push.n == 2'd1);
    push.r1.last = (push.n == 2'd2);
  end

endmodule

// ===== hdl/csvt_out_fifo.sv =====
// ----------------------------------------------------------------------------
// csvt_out_fifo
// Three-entry result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module csvt_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  csvt_pkg::push_t   push,
  output logic              has_room,
  output logic              out_valid,
  input  logic              out_ready,
  output csvt_pkg::result_t out_data
);
  import csvt_pkg::*;

  localparam int DEPTH = 3;

  result_t    mem_r [DEPTH];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] wr_p1;
  logic       pop;

  function automatic logic [1:0] inc3(input logic [1:0] p);
    return (p == 2'(DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  // room for the worst case of two results
  assign has_room  = (cnt_r <= 2'd1);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  assign wr_p1     = inc3(wr_r);

  always_comb begin
    case (push.n)
      2'd1:    wr_nxt = wr_p1;
      2'd2:    wr_nxt = inc3(wr_p1);
      default: wr_nxt = wr_r;
    endcase
    rd_nxt  = pop ? inc3(rd_r) : rd_r;
    cnt_nxt = cnt_r - {1'b0, pop} + push.n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_p1] <= push.r1;
    end
  end

endmodule

// ===== hdl/csvt_checker.sv =====
// ----------------------------------------------------------------------------
// csvt_checker
// Port-level checks for the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "csv_stream_tokenizer_unit_assert.svh"

module csvt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_event_kind,
  input logic [7:0]  out_field_byte,
  input logic [31:0] out_error_line,
  input logic        out_last_of_run
);
  import csvt_pkg::*;

  logic [43:0] out_bus;
  logic        out_stall;
  logic        ev_err;
  logic        ev_byte;
  logic        ev_done;

  assign out_bus   = {out_event_kind, out_field_byte, out_error_line, out_last_of_run};
  assign out_stall = out_valid && !out_ready;
  assign ev_err    = (out_event_kind == EV_ERROR);
  assign ev_byte   = (out_event_kind == EV_BYTE);
  assign ev_done   = (out_event_kind == EV_DONE);

  // a stalled result holds
  `CSVT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_bus))

  // line number only rides on errors
  `CSVT_ASSERT_IMPL(a_line_zero, clk, rst_n, out_valid && !ev_err, out_error_line == 32'd0)

  // data byte only rides on byte events
  `CSVT_ASSERT_IMPL(a_byte_zero, clk, rst_n, out_valid && !ev_byte, out_field_byte == 8'd0)

  // error and done always close an item's run
  `CSVT_ASSERT_IMPL(a_term_last, clk, rst_n, out_valid && (ev_err || ev_done), out_last_of_run)

  // event kind stays in the defined range
  `CSVT_ASSERT_IMPL(a_kind_range, clk, rst_n, out_valid, out_event_kind <= EV_DONE)

endmodule

bind csv_stream_tokenizer_unit csvt_checker u_csvt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_event_kind  (out_event_kind),
  .out_field_byte  (out_field_byte),
  .out_error_line  (out_error_line),
  .out_last_of_run (out_last_of_run)
);
